// File: rtl/capseg_pkg.sv
// Shared types, constants and tables of the capsule segment core.
// Used by capseg_ctrl, capseg_dp and the top level.
package capseg_pkg;

  localparam int FRAC_BITS_DEF    = 16;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_ENTRIES     = 24;
  localparam int ATAN_IDX_W       = 5;
  localparam int CFG_AW           = 3;
  localparam int MUL_AW           = 37;
  localparam int MUL_BW           = 16;
  localparam int ACC_W            = 69;
  localparam int CRD_W            = 37;
  localparam int ANG_W            = 33;
  localparam int OUT_DATA_W       = 208;
  localparam int IN_DATA_W        = 64;

  localparam logic [29:0] HALF_PI_Q29   = 30'd843314857;
  localparam logic [31:0] INV_GAIN_Q28  = 32'd163008218;
  localparam logic [15:0] ROT_LIMIT     = 16'd25736;

  localparam logic [CFG_AW-1:0] REG_ORIGIN_X  = 3'd0;
  localparam logic [CFG_AW-1:0] REG_ORIGIN_Y  = 3'd1;
  localparam logic [CFG_AW-1:0] REG_VIEW_BOX  = 3'd2;
  localparam logic [CFG_AW-1:0] REG_EXTENT    = 3'd3;
  localparam logic [CFG_AW-1:0] REG_STROKE_W  = 3'd4;
  localparam logic [CFG_AW-1:0] REG_MIN_RATIO = 3'd5;

  typedef enum logic [1:0] {
    MSRC_X,
    MSRC_Y,
    MSRC_MIN,
    MSRC_LEN
  } msrc_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MXL,
    S_MXH,
    S_MXF,
    S_MYL,
    S_MYH,
    S_MYF,
    S_MNL,
    S_MNH,
    S_DEC,
    S_CORD,
    S_LNL,
    S_LNH,
    S_EMIT,
    S_SEGB
  } state_t;

  typedef struct packed {
    logic  load;
    logic  mul_lo;
    logic  mul_hi;
    msrc_t src;
    logic  fin_x;
    logic  fin_y;
    logic  fin_min;
    logic  store_first;
    logic  store_prev;
    logic  seg_start;
    logic  seg_b;
    logic  cordic_step;
    logic  emit;
    logic  run_last;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic cordic_last;
    logic out_free;
  } stat_t;

  function automatic logic [29:0] atan_q29(input logic [ATAN_IDX_W-1:0] idx);
    logic [29:0] v;
    unique case (idx)
      5'd0:  v = 30'd421657428;
      5'd1:  v = 30'd248918915;
      5'd2:  v = 30'd131521918;
      5'd3:  v = 30'd66762579;
      5'd4:  v = 30'd33510843;
      5'd5:  v = 30'd16771758;
      5'd6:  v = 30'd8387925;
      5'd7:  v = 30'd4194219;
      5'd8:  v = 30'd2097141;
      5'd9:  v = 30'd1048575;
      5'd10: v = 30'd524288;
      5'd11: v = 30'd262144;
      5'd12: v = 30'd131072;
      5'd13: v = 30'd65536;
      5'd14: v = 30'd32768;
      5'd15: v = 30'd16384;
      5'd16: v = 30'd8192;
      5'd17: v = 30'd4096;
      5'd18: v = 30'd2048;
      5'd19: v = 30'd1024;
      5'd20: v = 30'd512;
      5'd21: v = 30'd256;
      5'd22: v = 30'd128;
      5'd23: v = 30'd64;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/capseg_ctrl.sv
// Sequencing state machine of the capsule segment core.
// Depends on capseg_pkg; drives capseg_dp through cmd_t and reads stat_t.
module capseg_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic                   in_tlast,
  input  logic [2:0]             in_tuser,
  input  capseg_pkg::stat_t      stat,
  output capseg_pkg::cmd_t       cmd
);

  capseg_pkg::state_t state_r, state_nxt;
  logic [1:0] cpts_r, cpts_nxt;
  logic       cstart_r, cend_r, closed_r, seg_b_r, seg_b_nxt;
  logic       accept;
  logic       wrap;

  assign accept = in_tvalid && in_tready;
  assign wrap   = cend_r && closed_r && !seg_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= capseg_pkg::S_IDLE;
      cpts_r  <= 2'd0;
      seg_b_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cpts_r  <= cpts_nxt;
      seg_b_r <= seg_b_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cstart_r <= in_tuser[1];
      cend_r   <= in_tlast;
      closed_r <= in_tuser[2];
    end
  end

  always_comb begin
    state_nxt = state_r;
    cpts_nxt  = cpts_r;
    seg_b_nxt = seg_b_r;
    unique case (state_r)
      capseg_pkg::S_IDLE: if (accept) state_nxt = capseg_pkg::S_MXL;
      capseg_pkg::S_MXL:  state_nxt = capseg_pkg::S_MXH;
      capseg_pkg::S_MXH:  state_nxt = capseg_pkg::S_MXF;
      capseg_pkg::S_MXF:  state_nxt = capseg_pkg::S_MYL;
      capseg_pkg::S_MYL:  state_nxt = capseg_pkg::S_MYH;
      capseg_pkg::S_MYH:  state_nxt = capseg_pkg::S_MYF;
      capseg_pkg::S_MYF:  state_nxt = capseg_pkg::S_MNL;
      capseg_pkg::S_MNL:  state_nxt = capseg_pkg::S_MNH;
      capseg_pkg::S_MNH:  state_nxt = capseg_pkg::S_DEC;
      capseg_pkg::S_DEC: begin
        seg_b_nxt = 1'b0;
        if (cstart_r || cpts_r == 2'd0) begin
          cpts_nxt  = cend_r ? 2'd0 : 2'd1;
          state_nxt = capseg_pkg::S_IDLE;
        end else begin
          cpts_nxt  = 2'd2;
          state_nxt = capseg_pkg::S_CORD;
        end
      end
      capseg_pkg::S_CORD: if (stat.cordic_last) state_nxt = capseg_pkg::S_LNL;
      capseg_pkg::S_LNL:  state_nxt = capseg_pkg::S_LNH;
      capseg_pkg::S_LNH:  state_nxt = capseg_pkg::S_EMIT;
      capseg_pkg::S_EMIT: begin
        if (stat.out_free) begin
          if (wrap) begin
            state_nxt = capseg_pkg::S_SEGB;
          end else begin
            if (cend_r) cpts_nxt = 2'd0;
            state_nxt = capseg_pkg::S_IDLE;
          end
        end
      end
      capseg_pkg::S_SEGB: begin
        seg_b_nxt = 1'b1;
        state_nxt = capseg_pkg::S_CORD;
      end
      default: state_nxt = capseg_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    cmd.src   = capseg_pkg::MSRC_X;
    in_tready = 1'b0;
    unique case (state_r)
      capseg_pkg::S_IDLE: begin
        in_tready = !stat.div_busy;
        cmd.load  = accept;
      end
      capseg_pkg::S_MXL: cmd.mul_lo = 1'b1;
      capseg_pkg::S_MXH: cmd.mul_hi = 1'b1;
      capseg_pkg::S_MXF: cmd.fin_x  = 1'b1;
      capseg_pkg::S_MYL: begin
        cmd.mul_lo = 1'b1;
        cmd.src    = capseg_pkg::MSRC_Y;
      end
      capseg_pkg::S_MYH: begin
        cmd.mul_hi = 1'b1;
        cmd.src    = capseg_pkg::MSRC_Y;
      end
      capseg_pkg::S_MYF: cmd.fin_y = 1'b1;
      capseg_pkg::S_MNL: begin
        cmd.mul_lo = 1'b1;
        cmd.src    = capseg_pkg::MSRC_MIN;
      end
      capseg_pkg::S_MNH: begin
        cmd.mul_hi = 1'b1;
        cmd.src    = capseg_pkg::MSRC_MIN;
      end
      capseg_pkg::S_DEC: begin
        cmd.fin_min    = 1'b1;
        cmd.store_prev = 1'b1;
        if (cstart_r || cpts_r == 2'd0) cmd.store_first = 1'b1;
        else                            cmd.seg_start   = 1'b1;
      end
      capseg_pkg::S_CORD: cmd.cordic_step = 1'b1;
      capseg_pkg::S_LNL: begin
        cmd.mul_lo = 1'b1;
        cmd.src    = capseg_pkg::MSRC_LEN;
      end
      capseg_pkg::S_LNH: begin
        cmd.mul_hi = 1'b1;
        cmd.src    = capseg_pkg::MSRC_LEN;
      end
      capseg_pkg::S_EMIT: begin
        cmd.emit     = stat.out_free;
        cmd.run_last = !wrap;
      end
      capseg_pkg::S_SEGB: begin
        cmd.seg_start = 1'b1;
        cmd.seg_b     = 1'b1;
      end
      default: cmd.load = 1'b0;
    endcase
  end

`ifndef SYNTH
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> stat.out_free) else $error("result written over a waiting one");
  a_no_accept_div: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !stat.div_busy) else $error("item taken during scale division");
  a_cpts_range: assert property (@(posedge clk) disable iff (!rst_n)
    cpts_r != 2'd3) else $error("contour point count out of range");
  a_segb_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == capseg_pkg::S_SEGB |-> $past(cmd.emit)) else $error("wrap without result");
`endif

endmodule

// File: rtl/capseg_dp.sv
// Datapath of the capsule segment core: registers, scale divider, mapping
// multiplier, CORDIC vectoring unit and result register. Depends on capseg_pkg.
module capseg_dp #(
  parameter int FRAC_BITS    = capseg_pkg::FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = capseg_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [capseg_pkg::CFG_AW-1:0]       cfg_addr,
  input  logic [31:0]                         cfg_wdata,
  input  logic [capseg_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic                                in_path_start,
  input  capseg_pkg::cmd_t                    cmd,
  output capseg_pkg::stat_t                   stat,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [capseg_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic                                out_tuser,
  output logic                                out_tlast
);

  localparam int DW     = 31 + FRAC_BITS;
  localparam int DCW    = $clog2(DW + 1);
  localparam int NSTEP  = (CORDIC_STEPS < capseg_pkg::ATAN_ENTRIES) ?
                          CORDIC_STEPS : capseg_pkg::ATAN_ENTRIES;
  localparam int AW     = capseg_pkg::ACC_W;
  localparam int CW     = capseg_pkg::CRD_W;
  localparam int GW     = capseg_pkg::ANG_W;

  // configuration
  logic signed [31:0] org_x_r, org_y_r, vbox_r, ratio_r;
  logic [30:0]        extent_r, stroke_r;
  logic signed [31:0] box;
  logic [29:0]        rad;
  logic [30:0]        ratio_pos;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_x_r  <= '0;
      org_y_r  <= '0;
      vbox_r   <= 32'sd24 <<< FRAC_BITS;
      extent_r <= 31'd1 << FRAC_BITS;
      stroke_r <= 31'd1 << FRAC_BITS;
      ratio_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        capseg_pkg::REG_ORIGIN_X:  org_x_r  <= cfg_wdata;
        capseg_pkg::REG_ORIGIN_Y:  org_y_r  <= cfg_wdata;
        capseg_pkg::REG_VIEW_BOX:  vbox_r   <= cfg_wdata;
        capseg_pkg::REG_EXTENT:    extent_r <= cfg_wdata[30:0];
        capseg_pkg::REG_STROKE_W:  stroke_r <= cfg_wdata[30:0];
        capseg_pkg::REG_MIN_RATIO: ratio_r  <= cfg_wdata;
        default:                   org_x_r  <= org_x_r;
      endcase
    end
  end

  assign box       = (vbox_r > 0) ? vbox_r : (32'sd24 <<< FRAC_BITS);
  assign rad       = (stroke_r[30:1] == '0) ? 30'd1 : stroke_r[30:1];
  assign ratio_pos = ratio_r[31] ? 31'd0 : ratio_r[30:0];

  // scale divider, one quotient bit a cycle
  logic          div_go_r;
  logic [DCW-1:0] div_cnt_r;
  logic [DW-1:0] dvd_r, quo_r;
  logic [31:0]   rem_r;
  logic [32:0]   rem_sh;
  logic          rem_ge;
  logic [31:0]   scale;

  assign rem_sh = {rem_r, dvd_r[DW-1]};
  assign rem_ge = rem_sh >= {1'b0, box};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_go_r  <= 1'b1;
      div_cnt_r <= '0;
    end else begin
      div_go_r <= cfg_we && (cfg_addr == capseg_pkg::REG_VIEW_BOX ||
                             cfg_addr == capseg_pkg::REG_EXTENT);
      if (div_go_r)              div_cnt_r <= DCW'(DW);
      else if (div_cnt_r != '0)  div_cnt_r <= div_cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (div_go_r) begin
      dvd_r <= {extent_r, {FRAC_BITS{1'b0}}};
      rem_r <= '0;
      quo_r <= '0;
    end else if (div_cnt_r != '0) begin
      dvd_r <= {dvd_r[DW-2:0], 1'b0};
      rem_r <= rem_ge ? 32'(rem_sh - {1'b0, box}) : rem_sh[31:0];
      quo_r <= {quo_r[DW-2:0], rem_ge};
    end
  end

  assign scale = (|quo_r[DW-1:32]) ? 32'hFFFF_FFFF : quo_r[31:0];

  // point mapping
  logic [31:0]        mag_x_r, mag_y_r;
  logic               neg_x_r, neg_y_r;
  logic signed [32:0] dxi, dyi, half_box;

  assign half_box = 33'(box >>> 1);
  assign dxi = 33'($signed(in_tdata[31:0]))  - half_box;
  assign dyi = 33'($signed(in_tdata[63:32])) - half_box;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag_x_r <= dxi[32] ? 32'(-dxi) : dxi[31:0];
      mag_y_r <= dyi[32] ? 32'(-dyi) : dyi[31:0];
      neg_x_r <= dxi[32];
      neg_y_r <= !dyi[32];
    end
  end

  // shared multiplier, two 16-bit passes
  logic [capseg_pkg::MUL_AW-1:0] mul_a;
  logic [capseg_pkg::MUL_BW-1:0] mul_b;
  logic [capseg_pkg::MUL_AW+capseg_pkg::MUL_BW-1:0] prod;
  logic [AW-1:0] acc_r;
  logic signed [CW-1:0] cx_r, cy_r;

  always_comb begin
    unique case (cmd.src)
      capseg_pkg::MSRC_X: begin
        mul_a = capseg_pkg::MUL_AW'(mag_x_r);
        mul_b = cmd.mul_hi ? scale[31:16] : scale[15:0];
      end
      capseg_pkg::MSRC_Y: begin
        mul_a = capseg_pkg::MUL_AW'(mag_y_r);
        mul_b = cmd.mul_hi ? scale[31:16] : scale[15:0];
      end
      capseg_pkg::MSRC_MIN: begin
        mul_a = capseg_pkg::MUL_AW'({rad, 1'b0});
        mul_b = cmd.mul_hi ? {1'b0, ratio_pos[30:16]} : ratio_pos[15:0];
      end
      capseg_pkg::MSRC_LEN: begin
        mul_a = cx_r[capseg_pkg::MUL_AW-1:0];
        mul_b = cmd.mul_hi ? capseg_pkg::INV_GAIN_Q28[31:16]
                           : capseg_pkg::INV_GAIN_Q28[15:0];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (cmd.mul_lo)      acc_r <= AW'(prod);
    else if (cmd.mul_hi) acc_r <= acc_r + (AW'(prod) << 16);
  end

  logic [AW-1:0]        tmag;
  logic signed [AW+1:0] org_ext, msum;
  logic                 fneg;
  logic signed [31:0]   mapped;

  assign tmag    = acc_r >> FRAC_BITS;
  assign org_ext = (AW+2)'(cmd.fin_x ? org_x_r : org_y_r);
  assign fneg    = cmd.fin_x ? neg_x_r : neg_y_r;
  assign msum    = fneg ? org_ext - $signed({2'b00, tmag})
                        : org_ext + $signed({2'b00, tmag});
  assign mapped  = (msum > (AW+2)'(32'sh7FFF_FFFF)) ? 32'sh7FFF_FFFF :
                   (msum < -(AW+2)'(33'sh0_8000_0000)) ? 32'sh8000_0000 : msum[31:0];

  logic signed [31:0] px_r, py_r, prev_x_r, prev_y_r, first_x_r, first_y_r;
  logic [AW-1:0]      min_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_x_r  <= '0;
      prev_y_r  <= '0;
      first_x_r <= '0;
      first_y_r <= '0;
    end else begin
      if (cmd.store_prev) begin
        prev_x_r <= px_r;
        prev_y_r <= py_r;
      end
      if (cmd.store_first) begin
        first_x_r <= px_r;
        first_y_r <= py_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin_x)   px_r  <= mapped;
    if (cmd.fin_y)   py_r  <= mapped;
    if (cmd.fin_min) min_r <= acc_r >> FRAC_BITS;
  end

  // segment set-up and CORDIC vectoring
  logic signed [31:0] ax, ay, bx, by;
  logic signed [32:0] sdx, sdy, csx, csy;
  logic signed [CW-1:0] ex, ey;
  logic signed [GW-1:0] ang_r;
  logic signed [31:0]   cen_x_r, cen_y_r;
  logic                 zero_r;
  logic [capseg_pkg::ATAN_IDX_W-1:0] it_r;
  logic signed [CW-1:0] xs, ys;
  logic signed [GW-1:0] at;

  assign ax  = cmd.seg_b ? px_r : prev_x_r;
  assign ay  = cmd.seg_b ? py_r : prev_y_r;
  assign bx  = cmd.seg_b ? first_x_r : px_r;
  assign by  = cmd.seg_b ? first_y_r : py_r;
  assign sdx = 33'(bx) - 33'(ax);
  assign sdy = 33'(by) - 33'(ay);
  assign csx = 33'(bx) + 33'(ax);
  assign csy = 33'(by) + 33'(ay);
  assign ex  = CW'(sdx);
  assign ey  = CW'(sdy);
  assign xs  = cx_r >>> it_r;
  assign ys  = cy_r >>> it_r;
  assign at  = GW'(capseg_pkg::atan_q29(it_r));

  always_ff @(posedge clk) begin
    if (cmd.seg_start) begin
      cen_x_r <= csx[32:1];
      cen_y_r <= csy[32:1];
      zero_r  <= (sdx == '0) && (sdy == '0);
      it_r    <= '0;
      if (!sdx[32]) begin
        cx_r  <= ex;
        cy_r  <= ey;
        ang_r <= '0;
      end else if (!sdy[32]) begin
        cx_r  <= ey;
        cy_r  <= -ex;
        ang_r <= GW'(capseg_pkg::HALF_PI_Q29);
      end else begin
        cx_r  <= -ey;
        cy_r  <= ex;
        ang_r <= -GW'(capseg_pkg::HALF_PI_Q29);
      end
    end else if (cmd.cordic_step) begin
      it_r <= it_r + 1'b1;
      if (cy_r > 0) begin
        cx_r  <= cx_r + ys;
        cy_r  <= cy_r - xs;
        ang_r <= ang_r + at;
      end else begin
        cx_r  <= cx_r - ys;
        cy_r  <= cy_r + xs;
        ang_r <= ang_r - at;
      end
    end
  end

  // result
  logic [AW-1:0]        len;
  logic                 kept;
  logic [AW-1:0]        hsum;
  logic [30:0]          hw;
  logic signed [GW:0]   rsum;
  logic signed [GW-16:0] rq;
  logic [15:0]          rot;
  logic [31:0]          fig_r, drop_r, fig_n, drop_n;
  logic                 out_valid_r;
  logic [capseg_pkg::OUT_DATA_W-1:0] out_data_r;
  logic                 out_kept_r, out_last_r;

  assign len  = zero_r ? '0 : AW'((acc_r + (AW'(1) << 27)) >> 28);
  assign kept = !(len < min_r);
  assign hsum = (len >> 1) + AW'(rad);
  assign hw   = (hsum > AW'(31'h7FFF_FFFF)) ? 31'h7FFF_FFFF : hsum[30:0];
  assign rsum = (GW+1)'(ang_r) + (GW+1)'(32768);
  assign rq   = rsum[GW:16];
  assign rot  = zero_r ? 16'd0 :
                (rq > (GW-15)'($signed({1'b0, capseg_pkg::ROT_LIMIT}))) ?
                  capseg_pkg::ROT_LIMIT :
                (rq < -(GW-15)'($signed({1'b0, capseg_pkg::ROT_LIMIT}))) ?
                  16'(-capseg_pkg::ROT_LIMIT) : rq[15:0];
  assign fig_n  = (kept && fig_r != '1) ? fig_r + 1'b1 : fig_r;
  assign drop_n = (!kept && drop_r != '1) ? drop_r + 1'b1 : drop_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fig_r       <= '0;
      drop_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load && in_path_start) begin
        fig_r  <= '0;
        drop_r <= '0;
      end else if (cmd.emit) begin
        fig_r  <= fig_n;
        drop_r <= drop_n;
      end
      if (cmd.emit)          out_valid_r <= 1'b1;
      else if (out_tready)   out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_kept_r <= kept;
      out_last_r <= cmd.run_last;
      out_data_r <= {3'b000, drop_n, fig_n,
                     kept ? rot : 16'd0, rad, kept ? hw : 31'd0,
                     kept ? cen_y_r : 32'sd0, kept ? cen_x_r : 32'sd0};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kept_r;
  assign out_tlast  = out_last_r;

  assign stat.div_busy    = div_go_r || (div_cnt_r != '0);
  assign stat.cordic_last = (it_r == capseg_pkg::ATAN_IDX_W'(NSTEP - 1));
  assign stat.out_free    = !out_valid_r || out_tready;

endmodule

// File: rtl/polyline_to_capsule_segments_core.sv
// Top level of the capsule segment core: maps contour points to the plane and
// emits one capsule or drop record per segment. Depends on capseg_pkg,
// capseg_ctrl and capseg_dp.
//
// A point that closes no segment is mapped on x and y and its minimum length is
// computed before in_tready returns. A point that closes a segment also passes
// through the vectoring unit, its length scaling and the result register. The wrap
// segment of a closed contour passes through them once more. One shared 37x16
// multiplier and one CORDIC unit serve all steps. Each result also waits while
// the previous one is held by a low out_tready. After reset and after every write
// of view_box or extent, in_tready stays low while the scale division runs.
module polyline_to_capsule_segments_core #(
  parameter int FRAC_BITS    = capseg_pkg::FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = capseg_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [capseg_pkg::CFG_AW-1:0]       cfg_addr,
  input  logic [31:0]                         cfg_wdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // point_x, point_y
  input  logic [capseg_pkg::IN_DATA_W-1:0]    in_tdata,
  // path_start, contour_start, contour_closed
  input  logic [2:0]                          in_tuser,
  input  logic                                in_tlast,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // centre_x, centre_y, half_width, radius, rotation, figure_total,
  // dropped_total, zero padding
  output logic [capseg_pkg::OUT_DATA_W-1:0]   out_tdata,
  // kept
  output logic                                out_tuser,
  output logic                                out_tlast
);

  capseg_pkg::cmd_t  cmd;
  capseg_pkg::stat_t stat;

  capseg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tlast  (in_tlast),
    .in_tuser  (in_tuser),
    .stat      (stat),
    .cmd       (cmd)
  );

  capseg_dp #(
    .FRAC_BITS    (FRAC_BITS),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .in_tdata      (in_tdata),
    .in_path_start (in_tuser[0]),
    .cmd           (cmd),
    .stat          (stat),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .out_tlast     (out_tlast)
  );

endmodule

// File: dv/tb_polyline_to_capsule_segments_core.sv
// Testbench for polyline_to_capsule_segments_core: drives contour point streams
// and checks every capsule or drop item against an in-bench predictor.
// Depends on capseg_pkg and the core RTL only.
module tb_polyline_to_capsule_segments_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB = capseg_pkg::FRAC_BITS_DEF;
  localparam int SETTLE = 80;
  localparam int WATCHDOG = 20000;

  typedef struct {
    bit        kept;
    bit [31:0] centre_x;
    bit [31:0] centre_y;
    bit [30:0] half_width;
    bit [29:0] radius;
    bit [15:0] rotation;
    bit        run_last;
    bit [31:0] figure_total;
    bit [31:0] dropped_total;
  } capsule_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [capseg_pkg::CFG_AW-1:0] cfg_addr = '0;
  logic [31:0] cfg_wdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [capseg_pkg::IN_DATA_W-1:0] in_tdata = '0;
  logic [2:0] in_tuser = '0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [capseg_pkg::OUT_DATA_W-1:0] out_tdata;
  logic out_tuser;
  logic out_tlast;

  polyline_to_capsule_segments_core u_top (.*);

  always #6 clk = ~clk;

  // predictor state
  int origin_x, origin_y, view_box, min_ratio;
  bit [30:0] extent, stroke_w;
  int prev_x, prev_y, first_x, first_y;
  int contour_pts;
  bit [31:0] figures, drops, scale_q;

  capsule_t capsules_due[$];
  int errors = 0;
  int send_idle = 0, recv_stall = 0;
  int idle_cycles = 0;
  int results_seen = 0, points_sent = 0;

  function automatic longint box_value();
    return view_box > 0 ? longint'(view_box) : (longint'(24) << FB);
  endfunction

  function automatic void rescale();
    longint unsigned q;
    q = (longint'(extent) << FB) / longint'(box_value());
    scale_q = q > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : q[31:0];
  endfunction

  function automatic int map_axis(int v, int org, bit flip);
    longint d, t, s;
    longint unsigned mag, sc;
    bit neg;
    d = longint'(v) - (box_value() >>> 1);
    mag = d < 0 ? -d : d;
    sc = scale_q;
    t = (mag * sc) >> FB;
    neg = (d < 0) != flip;
    s = longint'(org) + (neg ? -t : t);
    if (s > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (s < -64'sd2147483648) return 32'h8000_0000;
    return int'(s);
  endfunction

  function automatic bit [29:0] radius_of();
    bit [29:0] r;
    r = stroke_w[30:1];
    return r == 0 ? 30'd1 : r;
  endfunction

  function automatic void add_segment(int ax, int ay, int bx, int by);
    capsule_t c;
    longint x, y, ang, xs, ys, rot, dx, dy;
    longint unsigned len, minimum, ratio, hw;
    dx = longint'(bx) - ax;
    dy = longint'(by) - ay;
    len = 0;
    rot = 0;
    if (dx != 0 || dy != 0) begin
      x = dx; y = dy; ang = 0;
      if (dx < 0) begin
        if (dy >= 0) begin
          x = dy; y = -dx; ang = capseg_pkg::HALF_PI_Q29;
        end else begin
          x = -dy; y = dx; ang = -longint'(capseg_pkg::HALF_PI_Q29);
        end
      end
      for (int i = 0; i < capseg_pkg::CORDIC_STEPS_DEF && i < capseg_pkg::ATAN_ENTRIES;
           i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y > 0) begin
          x += ys; y -= xs;
          ang += longint'(capseg_pkg::atan_q29(capseg_pkg::ATAN_IDX_W'(i)));
        end else begin
          x -= ys; y += xs;
          ang -= longint'(capseg_pkg::atan_q29(capseg_pkg::ATAN_IDX_W'(i)));
        end
      end
      len = (longint'(x) * longint'(capseg_pkg::INV_GAIN_Q28) + (64'd1 << 27)) >> 28;
      rot = (ang + 32768) >>> 16;
      if (rot > longint'(capseg_pkg::ROT_LIMIT)) rot = capseg_pkg::ROT_LIMIT;
      if (rot < -longint'(capseg_pkg::ROT_LIMIT)) rot = -longint'(capseg_pkg::ROT_LIMIT);
    end
    ratio = min_ratio > 0 ? min_ratio : 0;
    minimum = (longint'(radius_of()) * 2 * ratio) >> FB;
    c = '{default: 0};
    c.radius = radius_of();
    if (len < minimum) begin
      if (drops != 32'hFFFF_FFFF) drops++;
    end else begin
      if (figures != 32'hFFFF_FFFF) figures++;
      hw = (len >> 1) + radius_of();
      if (hw > 64'h7FFF_FFFF) hw = 64'h7FFF_FFFF;
      c.kept = 1'b1;
      c.centre_x = 32'((longint'(ax) + bx) >>> 1);
      c.centre_y = 32'((longint'(ay) + by) >>> 1);
      c.half_width = hw[30:0];
      c.rotation = 16'(rot);
    end
    c.figure_total = figures;
    c.dropped_total = drops;
    capsules_due.push_back(c);
  endfunction

  function automatic void predict_point(int x, int y, bit ps, bit cs, bit ce, bit cl);
    int px, py, n;
    px = map_axis(x, origin_x, 1'b0);
    py = map_axis(y, origin_y, 1'b1);
    n = 0;
    if (ps) begin
      figures = 0; drops = 0;
    end
    if (cs || contour_pts == 0) begin
      first_x = px; first_y = py; contour_pts = 1;
    end else begin
      add_segment(prev_x, prev_y, px, py);
      n++;
      contour_pts = 2;
    end
    prev_x = px; prev_y = py;
    if (ce) begin
      if (cl && contour_pts >= 2) begin
        add_segment(px, py, first_x, first_y);
        n++;
      end
      contour_pts = 0;
    end
    if (n > 0) capsules_due[$].run_last = 1'b1;
  endfunction

  task automatic send_point(int x, int y, bit ps, bit cs, bit ce, bit cl);
    if ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {y, x};
    in_tuser <= {cl, cs, ps};
    in_tlast <= ce;
    predict_point(x, y, ps, cs, ce, cl);
    points_sent++;
    do @(negedge clk); while (!in_tready);
    @(posedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (capsules_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [capseg_pkg::CFG_AW-1:0] idx, logic [31:0] v);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= v;
    case (idx)
      capseg_pkg::REG_ORIGIN_X:  origin_x = v;
      capseg_pkg::REG_ORIGIN_Y:  origin_y = v;
      capseg_pkg::REG_VIEW_BOX:  begin view_box = v; rescale(); end
      capseg_pkg::REG_EXTENT:    begin extent = v[30:0]; rescale(); end
      capseg_pkg::REG_STROKE_W:  stroke_w = v[30:0];
      capseg_pkg::REG_MIN_RATIO: min_ratio = v;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // contour with small steps so that lengths, drops and angles spread well
  task automatic send_contour(int npts);
    int x, y, span;
    bit cl;
    x = $urandom_range(3) == 0 ? int'($urandom) : int'($urandom_range(48 << FB));
    y = $urandom_range(3) == 0 ? int'($urandom) : int'($urandom_range(48 << FB));
    span = 1 << $urandom_range(20);
    cl = $urandom_range(1);
    for (int i = 0; i < npts; i++) begin
      send_point(x, y, i == 0 && $urandom_range(7) == 0, i == 0, i == npts - 1, cl);
      if ($urandom_range(15) != 0) begin
        x += int'($urandom_range(2 * span)) - span;
        y += int'($urandom_range(2 * span)) - span;
      end
    end
  endtask

  task automatic random_config();
    write_reg(capseg_pkg::REG_ORIGIN_X,
              $urandom_range(3) == 0 ? $urandom : $urandom_range(1 << 20));
    write_reg(capseg_pkg::REG_ORIGIN_Y,
              $urandom_range(3) == 0 ? $urandom : $urandom_range(1 << 20));
    write_reg(capseg_pkg::REG_VIEW_BOX,
              $urandom_range(4) == 0 ? $urandom : $urandom_range(64 << FB));
    write_reg(capseg_pkg::REG_EXTENT,
              $urandom_range(4) == 0 ? $urandom : $urandom_range(64 << FB));
    write_reg(capseg_pkg::REG_STROKE_W,
              $urandom_range(3) == 0 ? $urandom : $urandom_range(4 << FB));
    write_reg(capseg_pkg::REG_MIN_RATIO,
              $urandom_range(2) == 0 ? $urandom : $urandom_range(4 << FB));
  endtask

  task automatic random_burst(int items);
    int sent;
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(9) == 0) begin
        send_point($urandom, $urandom, $urandom_range(1), $urandom_range(1),
                   $urandom_range(1), $urandom_range(1));
        sent++;
      end else begin
        int n;
        n = $urandom_range(1, 8);
        send_contour(n);
        sent += n;
      end
    end
  endtask

  task automatic test_directed();
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 1, 1, 0, 0);
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0, 0);
    send_point(0, 0, 0, 0, 1, 1);
    send_point(5 << FB, 5 << FB, 0, 0, 0, 0);     // orphan point opens a contour
    send_point(5 << FB, 5 << FB, 0, 0, 0, 0);     // zero-length segment
    send_point(1 << FB, 5 << FB, 0, 0, 0, 0);     // leftward, angle of pi
    send_point(9 << FB, 9 << FB, 0, 1, 0, 0);     // restart abandons open contour
    send_point(3 << FB, 2 << FB, 0, 0, 1, 1);     // closed contour of two points
    send_point(7 << FB, 7 << FB, 1, 1, 1, 1);     // single point, closed
    send_point(2 << FB, 3 << FB, 0, 1, 0, 0);
    send_point(2 << FB, 20 << FB, 0, 0, 0, 0);
    send_point(20 << FB, 20 << FB, 0, 0, 1, 0);
    drain();
    write_reg(capseg_pkg::REG_MIN_RATIO, 32'h0010_0000);
    send_point(0, 0, 1, 1, 0, 0);
    send_point(1 << FB, 0, 0, 0, 0, 0);           // dropped as too short
    send_point(24 << FB, 24 << FB, 0, 0, 1, 1);
    drain();
  endtask

  task automatic test_config_extremes();
    write_reg(capseg_pkg::REG_ORIGIN_X, 32'h7FFF_FFFF);
    write_reg(capseg_pkg::REG_ORIGIN_Y, 32'h8000_0000);
    write_reg(capseg_pkg::REG_VIEW_BOX, 32'h0000_0000);
    write_reg(capseg_pkg::REG_EXTENT, 32'h7FFF_FFFF);
    write_reg(capseg_pkg::REG_STROKE_W, 32'h0000_0000);
    write_reg(capseg_pkg::REG_MIN_RATIO, 32'h8000_0000);
    random_burst(20);
    drain();
    write_reg(capseg_pkg::REG_ORIGIN_X, 32'h8000_0000);
    write_reg(capseg_pkg::REG_ORIGIN_Y, 32'h7FFF_FFFF);
    write_reg(capseg_pkg::REG_VIEW_BOX, 32'h8000_0000);
    write_reg(capseg_pkg::REG_EXTENT, 32'h0000_0000);
    write_reg(capseg_pkg::REG_STROKE_W, 32'h7FFF_FFFF);
    write_reg(capseg_pkg::REG_MIN_RATIO, 32'h7FFF_FFFF);
    random_burst(15);
    drain();
    write_reg(capseg_pkg::REG_VIEW_BOX, 32'h0000_0001);
    write_reg(capseg_pkg::REG_EXTENT, 32'h0000_0001);
    write_reg(capseg_pkg::REG_STROKE_W, 32'h0000_0002);
    write_reg(capseg_pkg::REG_MIN_RATIO, 32'h0000_0000);
    random_burst(15);
    drain();
    write_reg(capseg_pkg::REG_VIEW_BOX, 32'h7FFF_FFFF);
    write_reg(capseg_pkg::REG_ORIGIN_X, 32'h0);
    write_reg(capseg_pkg::REG_ORIGIN_Y, 32'h0);
    random_burst(15);
    drain();
  endtask

  task automatic test_random(int s_idle, int r_stall, int items);
    send_idle = s_idle;
    recv_stall = r_stall;
    for (int k = 0; k < 5; k++) begin
      random_config();
      random_burst(items / 5);
      drain();
    end
  endtask

  always @(posedge clk) begin
    out_tready <= recv_stall == 0 ? 1'b1 : ($urandom_range(99) >= recv_stall);
  end

  always @(posedge clk) begin
    capsule_t c;
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
    else if (rst_n) idle_cycles++;
    if (idle_cycles >= WATCHDOG) begin
      $display("tb_polyline_to_capsule_segments_core: FAIL");
      $finish;
    end
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (capsules_due.size() == 0) begin
        $error("unexpected result item");
        errors++;
      end else begin
        c = capsules_due.pop_front();
        if (out_tuser !== c.kept) begin
          $error("kept exp %0d got %0d", c.kept, out_tuser); errors++;
        end
        if (out_tdata[31:0] !== c.centre_x) begin
          $error("centre_x exp %0h got %0h", c.centre_x, out_tdata[31:0]); errors++;
        end
        if (out_tdata[63:32] !== c.centre_y) begin
          $error("centre_y exp %0h got %0h", c.centre_y, out_tdata[63:32]); errors++;
        end
        if (out_tdata[94:64] !== c.half_width) begin
          $error("half_width exp %0h got %0h", c.half_width, out_tdata[94:64]); errors++;
        end
        if (out_tdata[124:95] !== c.radius) begin
          $error("radius exp %0h got %0h", c.radius, out_tdata[124:95]); errors++;
        end
        if (out_tdata[140:125] !== c.rotation) begin
          $error("rotation exp %0h got %0h", c.rotation, out_tdata[140:125]); errors++;
        end
        if (out_tdata[172:141] !== c.figure_total) begin
          $error("figure_total exp %0d got %0d", c.figure_total, out_tdata[172:141]);
          errors++;
        end
        if (out_tdata[204:173] !== c.dropped_total) begin
          $error("dropped_total exp %0d got %0d", c.dropped_total, out_tdata[204:173]);
          errors++;
        end
        if (out_tlast !== c.run_last) begin
          $error("run_last exp %0d got %0d", c.run_last, out_tlast); errors++;
        end
      end
    end
  end

  initial begin
    origin_x = 0; origin_y = 0; view_box = 24 << FB; min_ratio = 0;
    extent = 1 << FB; stroke_w = 1 << FB;
    prev_x = 0; prev_y = 0; first_x = 0; first_y = 0; contour_pts = 0;
    figures = 0; drops = 0;
    rescale();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_config_extremes();
    test_random(14, 59, 630);
    test_random(59, 14, 630);
    test_random(0, 0, 640);
    drain();
    $display("Covered %0d points and %0d result items over directed, extreme-register",
             points_sent, results_seen);
    $display("and randomised contour phases with sender and receiver stalls.");
    if (errors == 0 && capsules_due.size() == 0) begin
      $display("tb_polyline_to_capsule_segments_core: PASS");
    end else begin
      $display("tb_polyline_to_capsule_segments_core: FAIL");
    end
    $finish;
  end

endmodule
